### design/imu_sbc_pkg.sv
package imu_sbc_pkg;

	localparam int WORD_W = 16;
	localparam int N_WORDS = 7;
	localparam int TDATA_W = WORD_W * N_WORDS;
	localparam int IN_USER_W = 2;
	localparam int OUT_USER_W = 4;

	localparam int CAL_SAMPLES = 2000;
	localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
	localparam int SUM_W = 28;
	localparam int FAIL_W = 8;

	// Division by CAL_SAMPLES as a multiply by a rounded-up reciprocal.
	// With the shift set to the magnitude width plus log2 of the divisor,
	// the quotient is exact for every magnitude below 2**SUM_W.
	localparam int DIV_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
	localparam int RECIP_W = SUM_W + 1;
	localparam logic [63:0] RECIP_WIDE =
		((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];
	localparam int PROD_W = SUM_W + RECIP_W;

	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_FAIL = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;

	localparam logic [1:0] CFG_MANUAL_MODE = 2'd0;
	localparam logic [1:0] CFG_ACCEL_X_OFFSET = 2'd1;
	localparam logic [1:0] CFG_ACCEL_Y_OFFSET = 2'd2;
	localparam logic [1:0] CFG_FAILURE_LIMIT = 2'd3;

	localparam int USR_SAMPLE_VALID = 0;
	localparam int USR_DEVICE_RESET = 1;
	localparam int USR_CALIBRATING = 2;
	localparam int USR_CAL_DONE = 3;

	localparam logic [WORD_W-1:0] ACCEL_X_OFFSET_RST = 16'd257;
	localparam logic [WORD_W-1:0] ACCEL_Y_OFFSET_RST = 16'd92;
	localparam logic [FAIL_W-1:0] FAILURE_LIMIT_RST = 8'd100;
	localparam logic [WORD_W-1:0] GYRO_X_BIAS_RST = 16'hFEF4;
	localparam logic [WORD_W-1:0] GYRO_Y_BIAS_RST = 16'd124;
	localparam logic [WORD_W-1:0] GYRO_Z_BIAS_RST = 16'hFFD1;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic signed [SUM_W-1:0] sum_t;

endpackage

### design/imu_sample_bias_calibrator_top.sv
// IMU sample correction and gyro bias calibration.
// Input stream: s_axis_tuser carries the request kind (sample, failed read,
// start calibration) and s_axis_tdata the seven raw words of one frame.
// Output stream: one transfer per input transfer, with the corrected words in
// m_axis_tdata and the status flags in m_axis_tuser.
// The output is registered: a transfer accepted is shown on the output from the
// next cycle on. One item is taken per cycle while no bias divide is running and
// the output register is free or being drained in the same cycle.
// The item that ends a calibration starts a three-stage reciprocal divide
// (magnitude, multiply, shift and sign) that loads the new gyro bias; input
// is held off until the divide has loaded the bias.
// Configuration is written through cfg_we, cfg_index and cfg_wdata and takes
// effect at the next item.
// Reset clears the output valid, the failure and calibration counters and
// loads the default offsets, limit and gyro bias.
// When the receiver stalls, the pending result holds and s_axis_tready drops
// until the result has been taken.
module imu_sample_bias_calibrator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [imu_sbc_pkg::WORD_W-1:0]     cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// raw_accel_x, raw_accel_y, raw_accel_z, raw_temp, raw_gyro_x, raw_gyro_y, raw_gyro_z
	input  logic [imu_sbc_pkg::TDATA_W-1:0]    s_axis_tdata,
	// req_type
	input  logic [imu_sbc_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// accel_x, accel_y, accel_z, temp_word, gyro_x, gyro_y, gyro_z
	output logic [imu_sbc_pkg::TDATA_W-1:0]    m_axis_tdata,
	// sample_valid, device_reset, calibrating, cal_done
	output logic [imu_sbc_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import imu_sbc_pkg::*;

	logic               manual_mode_q;
	word_t              accel_x_offset_q;
	word_t              accel_y_offset_q;
	logic [FAIL_W-1:0]  failure_limit_q;

	word_t              gyro_bias_q [3];
	word_t              last_gyro_q [3];
	sum_t               bias_sum_q [3];
	logic [CNT_W-1:0]   cal_count_q;
	logic               cal_active_q;
	logic [FAIL_W-1:0]  fail_count_q;

	logic               div_start_q;
	logic               div_v_s1;
	logic               div_v_s2;
	logic [SUM_W-1:0]   div_mag_s1 [3];
	logic               div_neg_s1 [3];
	logic [PROD_W-1:0]  div_prod_s2 [3];
	logic               div_neg_s2 [3];

	logic               m_tvalid_q;
	logic [TDATA_W-1:0] m_tdata_q;
	logic [OUT_USER_W-1:0] m_tuser_q;

	logic [1:0]         req;
	word_t              raw [N_WORDS];
	word_t              accel_x;
	word_t              accel_y;
	word_t              accel_z;
	word_t              gyro_corr [3];
	word_t              acc_src [3];
	sum_t               sum_next [3];
	logic [CNT_W-1:0]   cnt_inc;
	logic [FAIL_W-1:0]  fail_inc;
	logic               fail_hit;
	logic               is_sample;
	logic               is_fail;
	logic               is_start;
	logic               cal_step;
	logic               cal_finish;
	logic               calibrating_next;
	logic               div_busy;
	logic               accept;
	logic [TDATA_W-1:0] data_next;
	logic [OUT_USER_W-1:0] user_next;

	always_comb begin
		req = s_axis_tuser;
		for (int i = 0; i < N_WORDS; i++) begin
			raw[i] = s_axis_tdata[i*WORD_W +: WORD_W];
		end
		accel_x = raw[0] - accel_x_offset_q;
		accel_y = (-raw[1]) - accel_y_offset_q;
		accel_z = -raw[2];
		gyro_corr[0] = raw[4] - gyro_bias_q[0];
		gyro_corr[1] = (-raw[5]) - gyro_bias_q[1];
		gyro_corr[2] = (-raw[6]) - gyro_bias_q[2];

		is_sample = (req == REQ_SAMPLE);
		is_fail = (req == REQ_FAIL);
		is_start = (req == REQ_START) && !manual_mode_q;

		for (int i = 0; i < 3; i++) begin
			acc_src[i] = is_sample ? gyro_corr[i] : last_gyro_q[i];
			sum_next[i] = bias_sum_q[i] +
				sum_t'({{(SUM_W-WORD_W){acc_src[i][WORD_W-1]}}, acc_src[i]});
		end

		cnt_inc = cal_count_q + CNT_W'(1);
		cal_step = cal_active_q && (is_sample || is_fail);
		cal_finish = cal_step && (cnt_inc >= CNT_W'(CAL_SAMPLES));

		fail_inc = fail_count_q + FAIL_W'(1);
		fail_hit = is_fail && (fail_inc >= failure_limit_q);

		if (is_start) begin
			calibrating_next = 1'b1;
		end else begin
			calibrating_next = cal_active_q && !cal_finish;
		end

		if (is_sample) begin
			data_next = {gyro_corr[2], gyro_corr[1], gyro_corr[0], raw[3],
				accel_z, accel_y, accel_x};
		end else begin
			data_next = '0;
		end
		user_next = '0;
		user_next[USR_SAMPLE_VALID] = is_sample;
		user_next[USR_DEVICE_RESET] = fail_hit;
		user_next[USR_CALIBRATING] = calibrating_next;
		user_next[USR_CAL_DONE] = cal_finish;
	end

	assign div_busy = div_start_q || div_v_s1 || div_v_s2;
	assign s_axis_tready = !div_busy && (!m_tvalid_q || m_axis_tready);
	assign accept = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata = m_tdata_q;
	assign m_axis_tuser = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_mode_q <= 1'b0;
			accel_x_offset_q <= ACCEL_X_OFFSET_RST;
			accel_y_offset_q <= ACCEL_Y_OFFSET_RST;
			failure_limit_q <= FAILURE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MANUAL_MODE: manual_mode_q <= cfg_wdata[0];
				CFG_ACCEL_X_OFFSET: accel_x_offset_q <= cfg_wdata;
				CFG_ACCEL_Y_OFFSET: accel_y_offset_q <= cfg_wdata;
				CFG_FAILURE_LIMIT: failure_limit_q <= cfg_wdata[FAIL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_bias_q[0] <= GYRO_X_BIAS_RST;
			gyro_bias_q[1] <= GYRO_Y_BIAS_RST;
			gyro_bias_q[2] <= GYRO_Z_BIAS_RST;
			for (int i = 0; i < 3; i++) begin
				last_gyro_q[i] <= '0;
				bias_sum_q[i] <= '0;
			end
			cal_count_q <= '0;
			cal_active_q <= 1'b0;
			fail_count_q <= '0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (accept) begin
				if (is_sample) begin
					fail_count_q <= '0;
					for (int i = 0; i < 3; i++) begin
						last_gyro_q[i] <= gyro_corr[i];
					end
				end
				if (is_fail) begin
					fail_count_q <= fail_hit ? '0 : fail_inc;
				end
				if (cal_step) begin
					for (int i = 0; i < 3; i++) begin
						bias_sum_q[i] <= sum_next[i];
					end
					if (cal_finish) begin
						cal_count_q <= '0;
						cal_active_q <= 1'b0;
						div_start_q <= 1'b1;
					end else begin
						cal_count_q <= cnt_inc;
					end
				end
				if (is_start) begin
					for (int i = 0; i < 3; i++) begin
						gyro_bias_q[i] <= '0;
						bias_sum_q[i] <= '0;
					end
					cal_count_q <= '0;
					cal_active_q <= 1'b1;
				end
			end else if (div_v_s2) begin
				for (int i = 0; i < 3; i++) begin
					gyro_bias_q[i] <= div_neg_s2[i] ?
						-div_prod_s2[i][DIV_SHIFT +: WORD_W] :
						div_prod_s2[i][DIV_SHIFT +: WORD_W];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s1 <= 1'b0;
			div_v_s2 <= 1'b0;
		end else begin
			div_v_s1 <= div_start_q;
			div_v_s2 <= div_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			div_neg_s1[i] <= bias_sum_q[i][SUM_W-1];
			div_mag_s1[i] <= bias_sum_q[i][SUM_W-1] ?
				-bias_sum_q[i] : bias_sum_q[i];
			div_neg_s2[i] <= div_neg_s1[i];
			div_prod_s2[i] <= PROD_W'(div_mag_s1[i]) * PROD_W'(RECIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= data_next;
			m_tuser_q <= user_next;
		end
	end

endmodule

### design/imu_sbc_checker.sv
module imu_sbc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [imu_sbc_pkg::TDATA_W-1:0]    m_axis_tdata,
	input logic [imu_sbc_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import imu_sbc_pkg::*;

	// A stalled result holds its data and flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output transfer changed");

	// Every accepted input produces a result on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted input gave no result");

	// The item that finishes calibration no longer reports calibrating.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[USR_CAL_DONE] |-> !m_axis_tuser[USR_CALIBRATING])
		else $error("calibration done while still calibrating");

	// Results without a sample carry zero words and never mix a reset request with a sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[USR_SAMPLE_VALID] |-> m_axis_tdata == '0)
		else $error("non-sample result carries data");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[USR_DEVICE_RESET] |->
			!m_axis_tuser[USR_SAMPLE_VALID])
		else $error("device reset flagged on a sample");

endmodule

bind imu_sample_bias_calibrator_top imu_sbc_checker u_imu_sbc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
